// ===== rtl/core/lossless_bitmap_to_dib_writer_defines.svh =====
`ifndef LOSSLESS_BITMAP_TO_DIB_WRITER_DEFINES_SVH
`define LOSSLESS_BITMAP_TO_DIB_WRITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LBDW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBDW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbdw_pkg.sv =====
package lbdw_pkg;

    localparam int DIM_BITS   = 16;
    localparam int ADDR_W     = 2 * DIM_BITS + 2;
    localparam int STRIDE_W   = DIM_BITS + 2;
    localparam int SLOT_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IS_TRUECOLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ENTRIES = 3'd4;

    localparam logic [SLOT_W-1:0] MAX_PALETTE = 9'd256;

    localparam logic       TGT_BITMAP  = 1'b0;
    localparam logic       TGT_PALETTE = 1'b1;
    localparam logic [1:0] CNT_INDEX   = 2'd1;
    localparam logic [1:0] CNT_COLOR   = 2'd3;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] src_byte;
    } t_in_item;

    typedef struct packed {
        logic              target;
        logic [ADDR_W-1:0] dest_index;
        logic [1:0]        byte_count;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [7:0]        byte2;
        logic              last_write;
    } t_out_item;

    typedef struct packed {
        logic                is_truecolor;
        logic                has_alpha;
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
        logic [SLOT_W-1:0]   palette_entries;
        logic                changed;
    } t_cfg;

    // c over white with alpha a, saturated
    function automatic logic [7:0] over_white(input logic [7:0] c, input logic [7:0] a);
        logic [8:0] v;
        v = {1'b0, c} + 9'd255 - {1'b0, a};
        return (v > 9'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

// ===== rtl/core/lossless_bitmap_to_dib_writer.sv =====
// A byte waits in the input queue; its result is registered in the result queue.
// Throughput: one byte per cycle while the result queue has room; after each config
// write, no byte is taken in the next cycle while the row-base product
// (height - 1) * stride is re-registered.
// Reset (i_rst_n low, synchronous): queues empty, counters cleared, registers at defaults.
`include "lossless_bitmap_to_dib_writer_defines.svh"

module lossless_bitmap_to_dib_writer import lbdw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_is_truecolor;
    logic                r_has_alpha;
    logic [DIM_BITS-1:0] r_image_width;
    logic [DIM_BITS-1:0] r_image_height;
    logic [SLOT_W-1:0]   r_palette_entries;
    logic                r_cfg_chg;
    t_cfg                s_cfg;
    logic                s_head_vld;
    t_in_item            s_head;
    logic                s_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_truecolor    <= 1'b0;
            r_has_alpha       <= 1'b0;
            r_image_width     <= DIM_BITS'(1);
            r_image_height    <= DIM_BITS'(1);
            r_palette_entries <= MAX_PALETTE;
            r_cfg_chg         <= 1'b0;
        end else begin
            r_cfg_chg <= i_cfg_wr_en;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_IS_TRUECOLOR:    r_is_truecolor    <= i_cfg_data[0];
                    REG_HAS_ALPHA:       r_has_alpha       <= i_cfg_data[0];
                    REG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[DIM_BITS-1:0];
                    REG_PALETTE_ENTRIES: r_palette_entries <= i_cfg_data[SLOT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        s_cfg.is_truecolor    = r_is_truecolor;
        s_cfg.has_alpha       = r_has_alpha;
        s_cfg.image_width     = r_image_width;
        s_cfg.image_height    = r_image_height;
        s_cfg.palette_entries = r_palette_entries;
        s_cfg.changed         = r_cfg_chg;
    end

    lbdw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_head_vld (s_head_vld),
        .o_head     (s_head),
        .i_take     (s_take)
    );

    lbdw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (s_cfg),
        .i_head_vld (s_head_vld),
        .i_head     (s_head),
        .o_take     (s_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (o_res)
    );

endmodule

// ===== rtl/core/lbdw_front.sv =====
module lbdw_front import lbdw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_head_vld,
    output t_in_item o_head,
    input  logic     i_take
);

    t_in_item   r_q0;
    t_in_item   r_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       s_push;
    logic       s_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_head_vld = (r_cnt != 2'd0);
    assign o_head     = r_q0;
    assign s_push     = i_push && !o_full;
    assign s_pop      = i_take && o_head_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (s_push && !s_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!s_push && s_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (s_push) begin
                r_q0 <= i_item;
            end
        end else if (s_push && r_cnt == 2'd0) begin
            r_q0 <= i_item;
        end
        if (s_push && ((r_cnt == 2'd1 && !s_pop) || (r_cnt == 2'd2 && s_pop))) begin
            r_q1 <= i_item;
        end
    end

endmodule

// ===== rtl/core/lbdw_back.sv =====
`include "lossless_bitmap_to_dib_writer_defines.svh"

module lbdw_back import lbdw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_head_vld,
    input  t_in_item  i_head,
    output logic      o_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_res
);

    typedef enum logic [1:0] {
        PH_PALETTE,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [1:0]          r_biu;
    logic [1:0]          n_biu;
    logic [7:0]          r_held [3];
    logic [7:0]          n_held [3];
    logic [DIM_BITS-1:0] r_col;
    logic [DIM_BITS-1:0] n_col;
    logic [DIM_BITS-1:0] r_rows;
    logic [DIM_BITS-1:0] n_rows;
    logic [ADDR_W-1:0]   r_rb;
    logic [ADDR_W-1:0]   n_rb;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [ADDR_W-1:0]   r_base0;
    logic [ADDR_W-1:0]   n_base0;

    t_out_item           r_oq0;
    t_out_item           r_oq1;
    logic [1:0]          r_ocnt;
    logic [1:0]          n_ocnt;

    logic [STRIDE_W-1:0] s_w1;
    logic [STRIDE_W-1:0] s_w3;
    logic [STRIDE_W-1:0] s_idx_stride;
    logic [STRIDE_W-1:0] s_stride;
    logic [DIM_BITS-1:0] s_hm1;
    logic [SLOT_W-1:0]   s_entries;
    logic [1:0]          s_size_m1;
    logic [STRIDE_W-1:0] s_col3;
    logic [7:0]          s_r;
    logic [7:0]          s_g;
    logic [7:0]          s_b;
    logic                s_end_row;
    logic                s_emit;
    t_out_item           s_res;
    logic                s_take;
    logic                s_opush;
    logic                s_opop;
    logic [7:0]          s_byte;
    logic [DIM_BITS-1:0] s_w;
    logic [DIM_BITS-1:0] s_h;

    assign s_byte = i_head.src_byte;
    assign s_w    = i_cfg.image_width;
    assign s_h    = i_cfg.image_height;

    // row strides of the output bitmap
    assign s_w1         = STRIDE_W'(s_w) + STRIDE_W'(3);
    assign s_w3         = (STRIDE_W'(s_w) << 1) + STRIDE_W'(s_w) + STRIDE_W'(3);
    assign s_idx_stride = {s_w1[STRIDE_W-1:2], 2'b00};
    assign s_stride     = i_cfg.is_truecolor ? {s_w3[STRIDE_W-1:2], 2'b00} : s_idx_stride;
    assign s_hm1        = s_h - DIM_BITS'(1);
    assign n_base0      = (s_h == '0) ? '0 : ADDR_W'(s_hm1) * ADDR_W'(s_stride);

    assign s_entries = (i_cfg.palette_entries > MAX_PALETTE) ? MAX_PALETTE
                                                             : i_cfg.palette_entries;
    assign s_size_m1 = i_cfg.has_alpha ? 2'd3 : 2'd2;

    assign s_take  = i_head_vld && (r_ocnt != 2'd2) && !i_cfg.changed;
    assign o_take  = s_take;
    assign s_opush = s_take && s_emit;
    assign s_opop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq0;

    always_comb begin
        n_phase   = r_phase;
        n_biu     = r_biu;
        n_held    = r_held;
        n_col     = r_col;
        n_rows    = r_rows;
        n_rb      = r_rb;
        n_slot    = r_slot;
        s_emit    = 1'b0;
        s_res     = '0;
        s_end_row = 1'b0;
        s_col3    = '0;
        s_r       = '0;
        s_g       = '0;
        s_b       = '0;

        if (i_head.frame_start) begin
            n_phase = PH_PALETTE;
            n_biu   = '0;
            n_col   = '0;
            n_rows  = '0;
            n_rb    = '0;
            n_slot  = '0;
            for (int i = 0; i < 3; i++) begin
                n_held[i] = '0;
            end
        end

        if (n_phase == PH_PALETTE) begin
            if (i_cfg.is_truecolor || n_slot >= s_entries) begin
                n_phase = PH_PIXELS;
                n_col   = '0;
                n_rows  = '0;
                n_biu   = '0;
                n_rb    = r_base0;
            end else if (n_biu < s_size_m1) begin
                for (int i = 0; i < 3; i++) begin
                    if (n_biu == 2'(i)) begin
                        n_held[i] = s_byte;
                    end
                end
                n_biu = n_biu + 2'd1;
            end else begin
                if (i_cfg.has_alpha) begin
                    s_r = over_white(n_held[0], s_byte);
                    s_g = over_white(n_held[1], s_byte);
                    s_b = over_white(n_held[2], s_byte);
                end else begin
                    s_r = n_held[0];
                    s_g = n_held[1];
                    s_b = s_byte;
                end
                s_emit           = 1'b1;
                s_res.target     = TGT_PALETTE;
                s_res.dest_index = ADDR_W'(n_slot);
                s_res.byte_count = CNT_COLOR;
                s_res.byte0      = s_b;
                s_res.byte1      = s_g;
                s_res.byte2      = s_r;
                n_slot           = n_slot + SLOT_W'(1);
                n_biu            = '0;
            end
        end

        if (n_phase == PH_PIXELS) begin
            if (s_w == '0 || s_h == '0 || n_rows >= s_h) begin
                n_phase = PH_DONE;
            end else if (!i_cfg.is_truecolor) begin
                if (n_col < s_w) begin
                    s_emit           = 1'b1;
                    s_res.target     = TGT_BITMAP;
                    s_res.dest_index = n_rb + ADDR_W'(n_col);
                    s_res.byte_count = CNT_INDEX;
                    s_res.byte0      = s_byte;
                    s_res.last_write = (n_col == s_w - DIM_BITS'(1))
                                    && (n_rows == s_h - DIM_BITS'(1));
                end
                if (STRIDE_W'(n_col) + STRIDE_W'(1) >= s_idx_stride) begin
                    s_end_row = 1'b1;
                end else begin
                    n_col = n_col + DIM_BITS'(1);
                end
            end else if (n_biu < 2'd3) begin
                for (int i = 0; i < 3; i++) begin
                    if (n_biu == 2'(i)) begin
                        n_held[i] = s_byte;
                    end
                end
                n_biu = n_biu + 2'd1;
            end else begin
                n_biu = '0;
                if (i_cfg.has_alpha) begin
                    s_r = over_white(n_held[1], n_held[0]);
                    s_g = over_white(n_held[2], n_held[0]);
                    s_b = over_white(s_byte, n_held[0]);
                end else begin
                    s_r = n_held[1];
                    s_g = n_held[2];
                    s_b = s_byte;
                end
                s_col3 = (STRIDE_W'(n_col) << 1) + STRIDE_W'(n_col);
                if (n_col < s_w) begin
                    s_emit           = 1'b1;
                    s_res.target     = TGT_BITMAP;
                    s_res.dest_index = n_rb + ADDR_W'(s_col3);
                    s_res.byte_count = CNT_COLOR;
                    s_res.byte0      = s_b;
                    s_res.byte1      = s_g;
                    s_res.byte2      = s_r;
                    s_res.last_write = (n_col == s_w - DIM_BITS'(1))
                                    && (n_rows == s_h - DIM_BITS'(1));
                end
                if ({1'b0, n_col} + (DIM_BITS + 1)'(1) >= {1'b0, s_w}) begin
                    s_end_row = 1'b1;
                end else begin
                    n_col = n_col + DIM_BITS'(1);
                end
            end

            if (s_end_row) begin
                n_col  = '0;
                n_rows = n_rows + DIM_BITS'(1);
                n_rb   = n_rb - ADDR_W'(s_stride);
                if (n_rows == '0 || n_rows >= s_h) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (s_opush && !s_opop) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (!s_opush && s_opop) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PALETTE;
            r_biu   <= '0;
            r_col   <= '0;
            r_rows  <= '0;
            r_rb    <= '0;
            r_slot  <= '0;
            r_ocnt  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            r_ocnt <= n_ocnt;
            if (s_take) begin
                r_phase <= n_phase;
                r_biu   <= n_biu;
                r_col   <= n_col;
                r_rows  <= n_rows;
                r_rb    <= n_rb;
                r_slot  <= n_slot;
                r_held  <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base0 <= n_base0;
        if (s_opop) begin
            if (r_ocnt == 2'd2) begin
                r_oq0 <= r_oq1;
            end else if (s_opush) begin
                r_oq0 <= s_res;
            end
        end else if (s_opush && r_ocnt == 2'd0) begin
            r_oq0 <= s_res;
        end
        if (s_opush && ((r_ocnt == 2'd1 && !s_opop) || (r_ocnt == 2'd2 && s_opop))) begin
            r_oq1 <= s_res;
        end
    end

    `LBDW_ASSERT_IMP(a_pal_write_form, s_opush && (s_res.target == TGT_PALETTE), !s_res.last_write && (s_res.byte_count == CNT_COLOR), "palette transfer malformed")
    `LBDW_ASSERT_NXT(a_done_after_last, s_opush && s_res.last_write && i_cfg.is_truecolor, r_phase == PH_DONE, "image not closed after last pixel")
    `LBDW_ASSERT_IMP(a_no_overrun, s_take, r_ocnt != 2'd2, "result queue overrun")

endmodule

// ===== tb/lbdw_write_checker.sv =====
`timescale 1ns / 1ps

module lbdw_write_checker import lbdw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_in_item              i_item,
    input  logic                  i_pop,
    input  logic                  i_empty,
    input  t_out_item             i_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);

    typedef enum logic [1:0] {LOAD_PALETTE, WRITE_PIXELS, IMAGE_DONE} t_stage;

    logic                sh_truecolor;
    logic                sh_alpha;
    logic [DIM_BITS-1:0] sh_width;
    logic [DIM_BITS-1:0] sh_height;
    logic [SLOT_W-1:0]   sh_entries;

    t_stage              stage;
    int unsigned         unit_pos;
    logic [7:0]          held [0:2];
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] rows;
    logic [ADDR_W-1:0]   row_addr;
    logic [SLOT_W-1:0]   slot;

    t_out_item expected_writes [$];
    int        pending_cnt = 0;
    int        mismatches = 0;

    assign o_pending = pending_cnt;
    assign o_errors  = mismatches;

    function automatic logic [ADDR_W-1:0] bitmap_stride();
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(sh_width);
        if (sh_truecolor) begin
            return (w * 3 + 3) & ~(ADDR_W'(3));
        end
        return (w + 3) & ~(ADDR_W'(3));
    endfunction

    function automatic logic [7:0] blend_white(input logic [7:0] c, input logic [7:0] a);
        int v;
        v = int'(c) + 255 - int'(a);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function automatic void clear_image();
        stage    = LOAD_PALETTE;
        unit_pos = 0;
        col      = '0;
        rows     = '0;
        slot     = '0;
        row_addr = '0;
        for (int i = 0; i < 3; i++) held[i] = 8'h00;
    endfunction

    function automatic void restore_defaults();
        sh_truecolor = 1'b0;
        sh_alpha     = 1'b0;
        sh_width     = 16'd1;
        sh_height    = 16'd1;
        sh_entries   = MAX_PALETTE;
        clear_image();
    endfunction

    function automatic void start_pixels();
        stage    = WRITE_PIXELS;
        col      = '0;
        rows     = '0;
        unit_pos = 0;
        row_addr = (sh_height != 0) ? ADDR_W'(sh_height - 16'd1) * bitmap_stride() : '0;
    endfunction

    // row_addr wraps like the address register; rows wraps at DIM_BITS
    function automatic void close_row();
        col      = '0;
        rows     = rows + 1'b1;
        row_addr = row_addr - bitmap_stride();
        if (rows == 0 || rows >= sh_height) stage = IMAGE_DONE;
    endfunction

    function automatic logic at_final_pixel();
        return (col == sh_width - 16'd1) && (rows == sh_height - 16'd1);
    endfunction

    function automatic void emit(input logic tgt, input logic [ADDR_W-1:0] addr,
                                 input logic [1:0] cnt, input logic [7:0] b0,
                                 input logic [7:0] b1, input logic [7:0] b2,
                                 input logic last);
        t_out_item wr;
        wr.target     = tgt;
        wr.dest_index = addr;
        wr.byte_count = cnt;
        wr.byte0      = b0;
        wr.byte1      = b1;
        wr.byte2      = b2;
        wr.last_write = last;
        expected_writes.push_back(wr);
    endfunction

    function automatic void predict_writes(input logic fs, input logic [7:0] b);
        int unsigned entries;
        int unsigned need;
        logic [7:0]  r, g, bl, a;
        if (fs) clear_image();

        if (stage == LOAD_PALETTE) begin
            entries = (sh_entries > 256) ? 256 : sh_entries;
            if (sh_truecolor || slot >= entries) begin
                start_pixels();
            end else begin
                need = sh_alpha ? 4 : 3;
                if (unit_pos < need - 1) begin
                    held[unit_pos] = b;
                    unit_pos++;
                    return;
                end
                if (sh_alpha) begin
                    r  = blend_white(held[0], b);
                    g  = blend_white(held[1], b);
                    bl = blend_white(held[2], b);
                end else begin
                    r  = held[0];
                    g  = held[1];
                    bl = b;
                end
                emit(TGT_PALETTE, ADDR_W'(slot), CNT_COLOR, bl, g, r, 1'b0);
                slot     = slot + 1'b1;
                unit_pos = 0;
                return;
            end
        end

        if (stage != WRITE_PIXELS) return;
        if (sh_width == 0 || sh_height == 0 || rows >= sh_height) begin
            stage = IMAGE_DONE;
            return;
        end

        if (!sh_truecolor) begin
            if (col < sh_width) begin
                emit(TGT_BITMAP, row_addr + ADDR_W'(col), CNT_INDEX, b, 8'h00, 8'h00,
                     at_final_pixel());
            end
            // source rows are padded to four bytes; padding is consumed silently
            if (int'(col) + 1 >= ((int'(sh_width) + 3) & ~3)) close_row();
            else col = col + 1'b1;
            return;
        end

        if (unit_pos < 3) begin
            held[unit_pos] = b;
            unit_pos++;
            return;
        end
        unit_pos = 0;
        a = held[0];
        if (sh_alpha) begin
            r  = blend_white(held[1], a);
            g  = blend_white(held[2], a);
            bl = blend_white(b, a);
        end else begin
            r  = held[1];
            g  = held[2];
            bl = b;
        end
        if (col < sh_width) begin
            emit(TGT_BITMAP, row_addr + ADDR_W'(col) * 3, CNT_COLOR, bl, g, r,
                 at_final_pixel());
        end
        if (int'(col) + 1 >= int'(sh_width)) close_row();
        else col = col + 1'b1;
    endfunction

    function automatic void check_write(input t_out_item got);
        t_out_item want;
        if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("write with none expected: tgt %0d dest %h cnt %0d bytes %h %h %h last %0d",
                         got.target, got.dest_index, got.byte_count, got.byte0, got.byte1,
                         got.byte2, got.last_write);
            end
            return;
        end
        want = expected_writes.pop_front();
        if (want.target !== got.target || want.dest_index !== got.dest_index ||
            want.byte_count !== got.byte_count || want.byte0 !== got.byte0 ||
            want.byte1 !== got.byte1 || want.byte2 !== got.byte2 ||
            want.last_write !== got.last_write) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("write mismatch (exp/got): tgt %0d/%0d dest %h/%h cnt %0d/%0d",
                         want.target, got.target, want.dest_index, got.dest_index,
                         want.byte_count, got.byte_count);
                $display("  bytes %h %h %h/%h %h %h last %0d/%0d",
                         want.byte0, want.byte1, want.byte2, got.byte0, got.byte1, got.byte2,
                         want.last_write, got.last_write);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
            expected_writes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_IS_TRUECOLOR:    sh_truecolor = i_cfg_data[0];
                    REG_HAS_ALPHA:       sh_alpha     = i_cfg_data[0];
                    REG_IMAGE_WIDTH:     sh_width     = i_cfg_data[DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT:    sh_height    = i_cfg_data[DIM_BITS-1:0];
                    REG_PALETTE_ENTRIES: sh_entries   = i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) predict_writes(i_item.frame_start, i_item.src_byte);
            if (i_pop && !i_empty) check_write(i_res);
        end
        pending_cnt = expected_writes.size();
    end

endmodule

// ===== tb/lossless_bitmap_to_dib_writer_tb.sv =====
`timescale 1ns / 1ps

module lossless_bitmap_to_dib_writer_tb import lbdw_pkg::*;;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_GOAL     = 1250;
    localparam int STALL_CYCLES  = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_res;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int pending;
    int errors;
    int cycles        = 0;
    int items_done    = 0;
    int bytes_sent    = 0;
    int results_taken = 0;
    int in_gap_ahead  = 1;
    bit burst_in      = 0;
    bit burst_out     = 0;
    bit steady_in     = 0;
    bit stall_request = 0;

    logic                cur_tc;
    logic                cur_al;
    logic [DIM_BITS-1:0] cur_w;
    logic [DIM_BITS-1:0] cur_h;
    logic [SLOT_W-1:0]   cur_pe;

    lossless_bitmap_to_dib_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lbdw_write_checker dib_write_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_pop       (pop),
        .i_empty     (empty),
        .i_res       (o_res),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // push stays high across back-to-back transfers; it is only lowered ahead of a gap
    task automatic send_byte(input logic fs, input logic [7:0] b);
        if (in_gap_ahead > 0) repeat (in_gap_ahead) @(posedge i_clk);
        push               <= 1'b1;
        i_item.frame_start <= fs;
        i_item.src_byte    <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
        if (bytes_sent % 64 == 0) burst_in = ($urandom_range(0, 3) == 0);
        in_gap_ahead = (burst_in || steady_in) ? 0 : $urandom_range(0, 13);
        if (in_gap_ahead != 0) push <= 1'b0;
    endtask

    task automatic settle();
        if (in_gap_ahead == 0) begin
            push <= 1'b0;
            in_gap_ahead = 1;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // unused upper data bits carry noise; the registers take only their own width
    task automatic write_regs(input logic tc, input logic al,
                              input logic [DIM_BITS-1:0] w,
                              input logic [DIM_BITS-1:0] h, input logic [SLOT_W-1:0] pe);
        logic [15:0] noise;
        noise = 16'($urandom);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_IS_TRUECOLOR;
        i_cfg_data  <= {noise[15:1], tc};
        @(posedge i_clk);
        i_cfg_index <= REG_HAS_ALPHA;
        i_cfg_data  <= {noise[14:0], al};
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= REG_PALETTE_ENTRIES;
        i_cfg_data  <= {noise[6:0], pe};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_tc = tc;
        cur_al = al;
        cur_w  = w;
        cur_h  = h;
        cur_pe = pe;
    endtask

    task automatic send_frame(input bit broken, input int cap);
        longint total;
        int     lim;
        int     tail;
        if (cur_tc) total = longint'(cur_w) * 4 * longint'(cur_h);
        else total = (longint'(cur_w) + 3) / 4 * 4 * longint'(cur_h);
        if (!cur_tc) total += longint'((cur_pe > 256) ? 256 : cur_pe) * (cur_al ? 4 : 3);
        if (cur_w == 0 || cur_h == 0) total += 3;
        lim = (total > cap) ? cap : int'(total);
        if (broken && lim > 1) lim = $urandom_range(1, lim);
        for (int k = 0; k < lim; k++) send_byte(k == 0, 8'($urandom));
        items_done += lim;
        if (!broken) begin
            tail = $urandom_range(0, 2);
            repeat (tail) send_byte(1'b0, 8'($urandom));
        end
    endtask

    initial begin
        int hold;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (stall_request) begin
                stall_request = 0;
                hold = STALL_CYCLES;
            end else begin
                if (results_taken % 64 == 0) burst_out = ($urandom_range(0, 3) == 0);
                hold = burst_out ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            results_taken++;
        end
    end

    initial begin
        logic                tc, al;
        logic [DIM_BITS-1:0] w, h;
        logic [SLOT_W-1:0]   pe;
        int                  cap;
        int                  nframes;
        int                  phase_no;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_IS_TRUECOLOR;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no frame start after reset: one palette entry, one index, row padding, stray byte
        write_regs(1'b0, 1'b0, 16'd1, 16'd1, 9'd1);
        send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'h00); send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h00); send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'h5A);
        send_byte(1'b0, 8'hA5); send_byte(1'b0, 8'h33);
        settle();
        // palette with alpha, saturating over white
        write_regs(1'b0, 1'b1, 16'd2, 16'd1, 9'd1);
        send_byte(1'b1, 8'h00); send_byte(1'b0, 8'hF5); send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h10); send_byte(1'b0, 8'h00); send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h77); send_byte(1'b0, 8'h88);
        settle();
        // truecolor skips the palette even with entries configured
        write_regs(1'b1, 1'b1, 16'd1, 16'd1, 9'd5);
        send_byte(1'b1, 8'h40); send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h80);
        settle();
        // empty palette
        write_regs(1'b0, 1'b0, 16'd1, 16'd1, 9'd0);
        send_byte(1'b1, 8'hC3); send_byte(1'b0, 8'h00); send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h00);
        settle();
        // zero width: palette still loads, pixel bytes are dropped
        write_regs(1'b0, 1'b0, 16'd0, 16'd1, 9'd1);
        send_byte(1'b1, 8'h01); send_byte(1'b0, 8'h02); send_byte(1'b0, 8'h03);
        send_byte(1'b0, 8'h04);

        phase_no = 0;
        while (items_done < ITEM_GOAL) begin
            phase_no++;
            tc      = 1'($urandom_range(0, 1));
            al      = 1'($urandom_range(0, 1));
            w       = 16'($urandom_range(1, 8));
            h       = 16'($urandom_range(1, 4));
            pe      = 9'($urandom_range(0, 8));
            cap     = 4096;
            nframes = $urandom_range(1, 3);
            case ($urandom_range(0, 29))
                0: begin
                    pe      = 9'($urandom_range(256, 511));
                    nframes = 1;
                end
                1: begin w = 16'hFFFF; cap = 80; end
                2: begin h = 16'hFFFF; cap = 80; end
                3: begin w = 16'hFFFF; h = 16'hFFFF; cap = 80; end
                4: w = 16'd0;
                5: h = 16'd0;
                default: ;
            endcase
            settle();
            if (phase_no == 1) begin
                // receiver holds off while a long run of index writes streams in
                write_regs(1'b0, 1'b0, 16'd64, 16'd4, 9'd0);
                steady_in     = 1;
                stall_request = 1;
                send_frame(1'b0, cap);
                steady_in = 0;
            end else begin
                if (phase_no == 2) begin
                    tc      = 1'b0;
                    pe      = 9'd300;
                    nframes = 1;
                end
                write_regs(tc, al, w, h, pe);
                repeat (nframes) send_frame($urandom_range(0, 5) == 0, cap);
            end
        end

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
